/* rtl/qpd_pkg.sv */
package qpd_pkg;

    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_LF         = 8'h0A;

    localparam int RES_PER_ITEM = 3;
    localparam int QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } qpd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } qpd_out_t;

    // results produced by one input transaction
    typedef struct packed {
        logic [1:0]                       count;
        qpd_out_t [RES_PER_ITEM-1:0]      items;
    } qpd_res_t;

endpackage

/* rtl/qpd_decode.sv */
module qpd_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  qpd_pkg::qpd_in_t  in_data,
    input  logic            underscore_as_space,
    output qpd_pkg::qpd_res_t res
);
    import qpd_pkg::*;

    logic       equal_held_reg, equal_held_next;
    logic       second_held_reg, second_held_next;
    logic [7:0] held_char_reg, held_char_next;

    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        return r;
    endfunction

    logic [7:0]               c;
    logic [4:0]               cx;
    logic [4:0]               hx;
    logic                     do_plain;
    logic [1:0]               n;
    qpd_out_t [RES_PER_ITEM-1:0] items;

    always_comb
    begin
        c                = in_data.in_byte;
        cx               = hex_nib(c);
        hx               = hex_nib(held_char_reg);
        equal_held_next  = equal_held_reg;
        second_held_next = second_held_reg;
        held_char_next   = held_char_reg;
        do_plain         = 1'b0;
        n                = 2'd0;
        items            = '0;

        if (!equal_held_reg)
        begin
            do_plain = 1'b1;
        end
        else if (!second_held_reg)
        begin
            if (c == CH_LF)
            begin
                equal_held_next = 1'b0;
            end
            else if (cx[4] || c == CH_CR)
            begin
                second_held_next = 1'b1;
                held_char_next   = c;
            end
            else
            begin
                equal_held_next = 1'b0;
                items[n]        = '{out_byte: CH_EQUAL, out_valid: 1'b1, out_last: 1'b0};
                n               = n + 2'd1;
                do_plain        = 1'b1;
            end
        end
        else
        begin
            equal_held_next  = 1'b0;
            second_held_next = 1'b0;
            if (held_char_reg == CH_CR && c == CH_LF)
            begin
                // soft line break
            end
            else if (hx[4] && cx[4])
            begin
                items[n] = '{out_byte: {hx[3:0], cx[3:0]}, out_valid: 1'b1, out_last: 1'b0};
                n        = n + 2'd1;
            end
            else
            begin
                items[n] = '{out_byte: CH_EQUAL, out_valid: 1'b1, out_last: 1'b0};
                n        = n + 2'd1;
                items[n] = '{out_byte: held_char_reg, out_valid: 1'b1, out_last: 1'b0};
                n        = n + 2'd1;
                do_plain = 1'b1;
            end
        end

        if (do_plain)
        begin
            if (c == CH_EQUAL)
            begin
                equal_held_next  = 1'b1;
                second_held_next = 1'b0;
            end
            else
            begin
                items[n].out_byte  = (underscore_as_space && c == CH_UNDERSCORE) ? CH_SPACE : c;
                items[n].out_valid = 1'b1;
                items[n].out_last  = 1'b0;
                n                  = n + 2'd1;
            end
        end

        // end of stream: flush held characters literally and mark the last result
        if (in_data.in_last)
        begin
            if (equal_held_next)
            begin
                items[n] = '{out_byte: CH_EQUAL, out_valid: 1'b1, out_last: 1'b0};
                n        = n + 2'd1;
                if (second_held_next)
                begin
                    items[n] = '{out_byte: held_char_next, out_valid: 1'b1, out_last: 1'b0};
                    n        = n + 2'd1;
                end
            end
            equal_held_next  = 1'b0;
            second_held_next = 1'b0;
            held_char_next   = 8'd0;
            if (n == 2'd0)
            begin
                items[0] = '{out_byte: 8'd0, out_valid: 1'b0, out_last: 1'b1};
                n        = 2'd1;
            end
            else
            begin
                items[2'(n - 2'd1)].out_last = 1'b1;
            end
        end

        res.count = n;
        res.items = items;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            equal_held_reg  <= 1'b0;
            second_held_reg <= 1'b0;
            held_char_reg   <= 8'd0;
        end
        else if (accept)
        begin
            equal_held_reg  <= equal_held_next;
            second_held_reg <= second_held_next;
            held_char_reg   <= held_char_next;
        end
    end

endmodule

/* rtl/quoted_printable_decoder.sv */
// a result is written into the result queue register when its input transaction is accepted
// throughput: one input transaction per cycle while each gives at most one result and results are taken
// an input giving two or three results sends them out one at a time
// through a four-entry result queue; input ready whenever at most one result waits
// reset (rst_n, asynchronous, active low) clears held characters, the queue and the mode bit
module quoted_printable_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  qpd_pkg::qpd_in_t  in_data,
    output logic              res_valid,
    input  logic              res_ready,
    output qpd_pkg::qpd_out_t res_data
);
    import qpd_pkg::*;

    logic     underscore_reg;
    qpd_out_t [QUEUE_DEPTH-1:0] q_reg, q_next;
    logic [2:0] count_reg, count_next;

    logic     accept;
    logic     pop;
    logic [2:0] base;
    logic [1:0] push_n;
    qpd_res_t res;

    assign in_ready  = (count_reg <= 3'd1);
    assign accept    = in_valid && in_ready;
    assign res_valid = (count_reg != 3'd0);
    assign pop       = res_valid && res_ready;
    assign res_data  = q_reg[0];

    qpd_decode u_decode (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (accept),
        .in_data             (in_data),
        .underscore_as_space (underscore_reg),
        .res                 (res)
    );

    always_comb
    begin
        push_n = accept ? res.count : 2'd0;
        base   = count_reg - {2'd0, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
        end
        for (int k = 0; k < RES_PER_ITEM; k++)
        begin
            if (2'(k) < push_n)
                q_next[2'(base + 3'(k))] = res.items[k];
        end
        count_next = base + {1'b0, push_n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            underscore_reg <= 1'b0;
            count_reg      <= 3'd0;
            q_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                underscore_reg <= cfg_wr_data;
            count_reg <= count_next;
            q_reg     <= q_next;
        end
    end

endmodule

/* rtl/qpd_checker.sv */
module qpd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              res_valid,
    input logic              res_ready,
    input qpd_pkg::qpd_out_t res_data
);
    import qpd_pkg::*;

    // stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // an empty result only closes a stream
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.out_valid |-> res_data.out_last)
        else $error("empty result without last mark");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.out_valid |-> res_data.out_byte == 8'd0)
        else $error("empty result carries a byte");

    // back-pressure only with results waiting
    a_ready_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> res_valid)
        else $error("input stalled with no pending result");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import qpd_pkg::*;

    localparam int LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    qpd_in_t in_data = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    qpd_out_t res_data;

    qpd_in_t char_q[$];
    qpd_out_t decoded_q[$];

    logic us_mode = 1'b0;
    logic eq_held = 1'b0;
    logic sec_held = 1'b0;
    logic [7:0] held_byte = 8'h00;

    logic calm = 1'b0;
    logic in_took;
    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int n_cfg = 0;
    int queued = 0;
    int cycles = 0;

    quoted_printable_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    always #6 clk = ~clk;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 10);
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 10);
        return 5'd16;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        qpd_out_t r;
        r.out_byte = b;
        r.out_valid = 1'b1;
        r.out_last = 1'b0;
        decoded_q.push_back(r);
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == CH_EQUAL)
        begin
            eq_held = 1'b1;
            sec_held = 1'b0;
        end
        else if (us_mode && c == CH_UNDERSCORE)
            push_byte(CH_SPACE);
        else
            push_byte(c);
    endfunction

    function automatic void decode_char(input qpd_in_t t);
        int start;
        logic [7:0] c;
        logic [4:0] hv;
        logic [4:0] cv;
        qpd_out_t r;
        start = decoded_q.size();
        c = t.in_byte;
        if (!eq_held)
            plain_char(c);
        else if (!sec_held)
        begin
            if (c == CH_LF)
                eq_held = 1'b0;
            else if (hex_val(c) != 5'd16 || c == CH_CR)
            begin
                sec_held = 1'b1;
                held_byte = c;
            end
            else
            begin
                eq_held = 1'b0;
                push_byte(CH_EQUAL);
                plain_char(c);
            end
        end
        else
        begin
            hv = hex_val(held_byte);
            cv = hex_val(c);
            eq_held = 1'b0;
            sec_held = 1'b0;
            if (held_byte == CH_CR && c == CH_LF)
                ;
            else if (hv != 5'd16 && cv != 5'd16)
                push_byte({hv[3:0], cv[3:0]});
            else
            begin
                push_byte(CH_EQUAL);
                push_byte(held_byte);
                plain_char(c);
            end
        end
        if (t.in_last)
        begin
            if (eq_held)
            begin
                push_byte(CH_EQUAL);
                if (sec_held)
                    push_byte(held_byte);
            end
            eq_held = 1'b0;
            sec_held = 1'b0;
            held_byte = 8'h00;
            if (decoded_q.size() == start)
            begin
                r = '0;
                r.out_last = 1'b1;
                decoded_q.push_back(r);
            end
            else
            begin
                r = decoded_q.pop_back();
                r.out_last = 1'b1;
                decoded_q.push_back(r);
            end
        end
    endfunction

    // driver: new transaction or idle at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (char_q.size() > 0 && (calm || $urandom_range(0, 99) >= 11))
                begin
                    in_data <= char_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            res_ready <= calm || $urandom_range(0, 99) >= 11;
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            in_took <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                decode_char(in_data);
                n_in++;
            end
            if (res_valid && res_ready)
            begin
                n_out++;
                if (decoded_q.size() == 0)
                begin
                    $display("%0t unexpected result: got byte %02h valid %b last %b",
                             $time, res_data.out_byte, res_data.out_valid, res_data.out_last);
                    errors++;
                end
                else
                begin
                    if (res_data.out_byte !== decoded_q[0].out_byte ||
                        res_data.out_valid !== decoded_q[0].out_valid ||
                        res_data.out_last !== decoded_q[0].out_last)
                    begin
                        $display({"%0t mismatch: expected byte %02h valid %b last %b, ",
                                  "got byte %02h valid %b last %b"},
                                 $time, decoded_q[0].out_byte, decoded_q[0].out_valid,
                                 decoded_q[0].out_last, res_data.out_byte,
                                 res_data.out_valid, res_data.out_last);
                        errors++;
                    end
                    void'(decoded_q.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, decoded_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic put(input logic [7:0] b, input logic l);
        qpd_in_t t;
        t.in_byte = b;
        t.in_last = l;
        char_q.push_back(t);
        queued++;
    endtask

    function automatic logic [7:0] rand_hex();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 10)
            return "0" + v;
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    task automatic set_mode(input logic v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        us_mode = v;
        n_cfg++;
    endtask

    // wait for every transaction and result, then let the pipeline empty
    task automatic drain();
        while (char_q.size() > 0 || in_valid)
            @(negedge clk);
        while (decoded_q.size() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic gen_stream();
        logic [7:0] s[$];
        int tokens;
        int r;
        int k;
        logic [7:0] b;
        if ($urandom_range(0, 99) < 10)
        begin
            // noise
            tokens = $urandom_range(1, 6);
            for (k = 0; k < tokens; k++)
                s.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            tokens = $urandom_range(1, 8);
            for (k = 0; k < tokens; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_EQUAL)
                        b = CH_UNDERSCORE;
                    s.push_back(b);
                end
                else if (r < 45)
                    s.push_back(CH_UNDERSCORE);
                else if (r < 70)
                begin
                    s.push_back(CH_EQUAL);
                    s.push_back(rand_hex());
                    s.push_back(rand_hex());
                end
                else if (r < 77)
                begin
                    s.push_back(CH_EQUAL);
                    s.push_back(CH_LF);
                end
                else if (r < 83)
                begin
                    s.push_back(CH_EQUAL);
                    s.push_back(CH_CR);
                    s.push_back(CH_LF);
                end
                else if (r < 91)
                begin
                    s.push_back(CH_EQUAL);
                    s.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    s.push_back(CH_EQUAL);
                    s.push_back($urandom_range(0, 1) ? CH_CR : rand_hex());
                    s.push_back(8'($urandom_range(0, 255)));
                end
            end
            // escape cut short by the end of the stream
            r = $urandom_range(0, 99);
            if (r < 8)
                s.push_back(CH_EQUAL);
            else if (r < 15)
            begin
                s.push_back(CH_EQUAL);
                s.push_back($urandom_range(0, 1) ? CH_CR : rand_hex());
            end
        end
        for (k = 0; k < s.size(); k++)
            put(s[k], k == s.size() - 1);
    endtask

    initial
    begin
        int p;
        int mark;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0);
        put(8'h00, 1'b0);
        put(8'hFF, 1'b0);
        put(CH_EQUAL, 1'b0); put("4", 1'b0); put("1", 1'b0);
        put(CH_EQUAL, 1'b0); put("f", 1'b0); put("F", 1'b0);
        put(CH_EQUAL, 1'b0); put(CH_LF, 1'b0);
        put(CH_EQUAL, 1'b0); put(CH_CR, 1'b0); put(CH_LF, 1'b0);
        put(CH_EQUAL, 1'b0); put("+", 1'b0);
        put(CH_EQUAL, 1'b0); put("4", 1'b0); put(" ", 1'b0);
        put(CH_EQUAL, 1'b0); put(CH_CR, 1'b0); put(CH_UNDERSCORE, 1'b0);
        put(CH_EQUAL, 1'b0); put("5", 1'b1);
        drain();

        set_mode(1'b1);
        put(CH_UNDERSCORE, 1'b0);
        put(CH_EQUAL, 1'b0); put("5", 1'b0); put("F", 1'b0);
        put(CH_EQUAL, 1'b0); put(CH_EQUAL, 1'b1);
        put(CH_EQUAL, 1'b0); put(CH_LF, 1'b1);
        put(CH_UNDERSCORE, 1'b1);
        drain();

        for (p = 0; p < 6; p++)
        begin
            set_mode(p % 2 == 0);
            @(posedge clk);
            calm = (p == 3);
            mark = queued;
            while (queued - mark < 22)
                gen_stream();
            drain();
        end

        $display("%0d characters in, %0d results checked, %0d mode writes",
                 n_in, n_out, n_cfg);
        $display("covered hex escapes, soft breaks, bad and truncated escapes, Q mode");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
